// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros included by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FIAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FIAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/fias_pkg.sv -----
// ----------------------------------------------------------------------------
// fias_pkg
// Types and constants of the force impulse and stretch statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fias_pkg;

    localparam logic [62:0] MAX63 = {63{1'b1}};
    localparam logic [31:0] MAX32 = {32{1'b1}};
    localparam int          ITERS = 32;
    localparam int          ITW   = $clog2(ITERS);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_SQX   = 16'h0002,
        S_SQY   = 16'h0004,
        S_SQZ   = 16'h0008,
        S_SQEND = 16'h0010,
        S_SQRT  = 16'h0020,
        S_TMUL  = 16'h0040,
        S_AREA  = 16'h0080,
        S_ODD   = 16'h0100,
        S_IMP   = 16'h0200,
        S_DIVM  = 16'h0400,
        S_PROD  = 16'h0800,
        S_M2    = 16'h1000,
        S_VAR   = 16'h2000,
        S_VDIV  = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    // start request and completion of an iterative unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

// ----- src/force_impulse_and_stretch_stats_top.sv -----
// ----------------------------------------------------------------------------
// force_impulse_and_stretch_stats_top
// Force impulse integration and running stretch statistics.
// ----------------------------------------------------------------------------
// One sample is taken at a time; o_ready is high only while idle. A baseline
// sample runs three squares on the shared multiplier, then the square root.
// Any later sample runs the square root, a division for the mean, and another
// division for the variance when the sample count is at least two and the
// quotient does not saturate. The result is held on the output until
// transferred.
`timescale 1ns / 1ps

module force_impulse_and_stretch_stats_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_timestamp,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [31:0] i_force_z,
    input  logic [31:0] i_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_baseline_only,
    output logic [31:0] o_sample_count,
    output logic [62:0] o_total_impulse,
    output logic [31:0] o_mean_stretch,
    output logic [31:0] o_stretch_variance,
    output logic [31:0] o_max_stretch
);
    import fias_pkg::*;

    localparam logic [31:0] LEASH_RST = 32'(3) << (FRAC_BITS - 1);

    t_state r_state, n_state;

    logic [31:0] r_leash;
    logic [31:0] r_ts, r_ax, r_ay, r_az, r_dist;
    logic [63:0] r_acc;
    logic [31:0] r_mag;
    logic        r_have_base;
    logic [31:0] r_last_time, r_last_mag;
    logic [31:0] r_count;
    logic [62:0] r_imp, r_area;
    logic [31:0] r_mean, r_peak, r_var, r_adelta;
    logic        r_neg;
    logic [63:0] r_m2;
    logic        r_base_only;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    t_unit_req   sqrt_req, div_req;
    t_unit_rsp   sqrt_rsp, div_rsp;
    logic [31:0] sqrt_root, div_quo;
    logic [31:0] div_hi, div_lo, div_den;

    logic [31:0] w_stretch, w_dt, w_absdelta, w_adelta2, w_cnt_m1;
    logic [32:0] w_sum;
    logic [63:0] w_odd_t, w_imp_t;
    logic [64:0] w_m2_t;
    logic [63:0] w_prod;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    assign w_stretch  = (r_dist > r_leash) ? (r_dist - r_leash) : '0;
    assign w_dt       = r_ts - r_last_time;
    assign w_sum      = {1'b0, r_last_mag} + {1'b0, r_mag};
    assign w_absdelta = (w_stretch >= r_mean) ? (w_stretch - r_mean) : (r_mean - w_stretch);
    assign w_adelta2  = (w_stretch >= r_mean) ? (w_stretch - r_mean) : (r_mean - w_stretch);
    assign w_cnt_m1   = r_count - 32'd1;
    assign w_odd_t    = {1'b0, r_area} + {33'd0, w_dt[31:1]};
    assign w_imp_t    = {1'b0, r_imp} + {1'b0, r_area};
    assign w_prod     = mul_p >> FRAC_BITS;
    assign w_m2_t     = {1'b0, r_m2} + {1'b0, w_prod};

    // shared multiplier operand select
    always_comb begin
        mul_a = r_ax;
        mul_b = r_ax;
        unique case (r_state)
            S_SQY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            S_SQZ: begin
                mul_a = r_az;
                mul_b = r_az;
            end
            S_TMUL: begin
                mul_a = w_dt;
                mul_b = w_sum[32:1];
            end
            S_PROD: begin
                mul_a = r_adelta;
                mul_b = w_adelta2;
            end
            default: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
        endcase
    end

    fias_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign sqrt_req.start = (r_state == S_SQEND);

    fias_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .i_v     (r_acc + mul_p),
        .o_rsp   (sqrt_rsp),
        .o_root  (sqrt_root)
    );

    // mean step divides |delta| by the count; variance divides m2 by count - 1
    always_comb begin
        div_req.start = 1'b0;
        div_hi        = '0;
        div_lo        = w_absdelta;
        div_den       = r_count;
        if (r_state == S_IMP) begin
            div_req.start = 1'b1;
        end else if (r_state == S_VAR) begin
            div_hi  = r_m2[63:32];
            div_lo  = r_m2[31:0];
            div_den = w_cnt_m1;
            div_req.start = (r_count >= 32'd2) && (r_m2[63:32] < w_cnt_m1);
        end
    end

    fias_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (div_req),
        .i_num_hi (div_hi),
        .i_num_lo (div_lo),
        .i_den    (div_den),
        .o_rsp    (div_rsp),
        .o_quo    (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQZ;
            S_SQZ:   n_state = S_SQEND;
            S_SQEND: n_state = S_SQRT;
            S_SQRT:  if (sqrt_rsp.done) n_state = r_have_base ? S_TMUL : S_OUT;
            S_TMUL:  n_state = S_AREA;
            S_AREA:  n_state = S_ODD;
            S_ODD:   n_state = S_IMP;
            S_IMP:   n_state = S_DIVM;
            S_DIVM:  if (div_rsp.done) n_state = S_PROD;
            S_PROD:  n_state = S_M2;
            S_M2:    n_state = S_VAR;
            S_VAR:   n_state = div_req.start ? S_VDIV : S_OUT;
            S_VDIV:  if (div_rsp.done) n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_leash     <= LEASH_RST;
            r_have_base <= 1'b0;
            r_last_time <= '0;
            r_last_mag  <= '0;
            r_count     <= '0;
            r_imp       <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_peak      <= '0;
            r_var       <= '0;
            r_base_only <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_leash <= i_cfg_data;
            end
            unique case (r_state)
                S_SQRT: begin
                    if (sqrt_rsp.done) begin
                        r_base_only <= !r_have_base;
                        if (!r_have_base) begin
                            r_have_base <= 1'b1;
                            r_last_time <= r_ts;
                            r_last_mag  <= sqrt_root;
                        end else begin
                            if (r_count != MAX32) r_count <= r_count + 32'd1;
                            if (w_stretch > r_peak) r_peak <= w_stretch;
                        end
                    end
                end
                S_IMP: begin
                    r_imp       <= w_imp_t[63] ? MAX63 : w_imp_t[62:0];
                    r_last_time <= r_ts;
                    r_last_mag  <= r_mag;
                end
                S_DIVM: begin
                    if (div_rsp.done) begin
                        r_mean <= r_neg ? (r_mean - div_quo) : (r_mean + div_quo);
                    end
                end
                S_M2: begin
                    r_m2 <= w_m2_t[64] ? {64{1'b1}} : w_m2_t[63:0];
                end
                S_VAR: begin
                    if (r_count < 32'd2) begin
                        r_var <= '0;
                    end else if (!div_req.start) begin
                        r_var <= MAX32;
                    end
                end
                S_VDIV: begin
                    if (div_rsp.done) r_var <= div_quo;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_ts   <= i_timestamp;
                    r_ax   <= abs32(i_force_x);
                    r_ay   <= abs32(i_force_y);
                    r_az   <= abs32(i_force_z);
                    r_dist <= i_distance;
                end
            end
            S_SQY:   r_acc <= mul_p;
            S_SQZ:   r_acc <= r_acc + mul_p;
            S_SQRT:  if (sqrt_rsp.done) r_mag <= sqrt_root;
            S_AREA:  r_area <= mul_p[63] ? MAX63 : mul_p[62:0];
            S_ODD: begin
                if (w_sum[0]) r_area <= w_odd_t[63] ? MAX63 : w_odd_t[62:0];
            end
            S_IMP: begin
                r_neg    <= w_stretch < r_mean;
                r_adelta <= w_absdelta;
            end
            default: begin
            end
        endcase
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_baseline_only    = r_base_only;
    assign o_sample_count     = r_count;
    assign o_total_impulse    = r_imp;
    assign o_mean_stretch     = r_mean;
    assign o_stretch_variance = r_var;
    assign o_max_stretch      = r_peak;

`include "assert_macros.svh"

    `FIAS_ASSERT(a_ready_excl, !(o_ready && o_valid), "ready while result pending")
    `FIAS_ASSERT(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "accepted twice")
    `FIAS_ASSERT(a_base_zero, o_valid && o_baseline_only |-> o_sample_count == 32'd0, "baseline count")
    `FIAS_ASSERT(a_var_zero, o_valid && o_sample_count < 32'd2 |-> o_stretch_variance == 32'd0, "variance early")

endmodule

// ----- src/fias_mul.sv -----
// ----------------------------------------------------------------------------
// fias_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fias_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 64'(i_a) * 64'(i_b);
    end
endmodule

// ----- src/fias_sqrt.sv -----
// ----------------------------------------------------------------------------
// fias_sqrt
// Iterative floor square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fias_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fias_pkg::t_unit_req i_req,
    input  logic [63:0]         i_v,
    output fias_pkg::t_unit_rsp o_rsp,
    output logic [31:0]         o_root
);
    import fias_pkg::*;

    logic [63:0]    r_v;
    logic [33:0]    r_rem;
    logic [31:0]    r_root;
    logic [ITW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;
    logic        w_ge;

    assign w_rem_sh = {r_rem[32:0], r_v[63:62]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITW'(ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_v   <= {r_v[61:0], 2'b00};
            r_cnt <= r_cnt + ITW'(1);
            if (w_ge) begin
                r_rem  <= 34'(w_rem_sh - w_trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_root     = r_root;
endmodule

// ----- src/fias_div.sv -----
// ----------------------------------------------------------------------------
// fias_div
// Restoring divider, 64 by 32 bits, one quotient bit a cycle.
// The upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fias_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fias_pkg::t_unit_req i_req,
    input  logic [31:0]         i_num_hi,
    input  logic [31:0]         i_num_lo,
    input  logic [31:0]         i_den,
    output fias_pkg::t_unit_rsp o_rsp,
    output logic [31:0]         o_quo
);
    import fias_pkg::*;

    logic [31:0]    r_rem;
    logic [31:0]    r_quo;
    logic [31:0]    r_den;
    logic [ITW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [32:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_quo[31]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITW'(ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_num_hi;
            r_quo <= i_num_lo;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + ITW'(1);
            if (w_ge) begin
                r_rem <= 32'(w_t - {1'b0, r_den});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_t[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_quo      = r_quo;
endmodule

// ----- test/tb_force_impulse_and_stretch_stats_top.sv -----
// ----------------------------------------------------------------------------
// tb_force_impulse_and_stretch_stats_top
// Self-checking test of the force impulse and stretch statistics block.
// ----------------------------------------------------------------------------
// Samples go in over a valid/ready channel. Each transfer is run through an
// in-bench predictor of magnitude, trapezoid impulse and Welford stretch
// statistics. Each result transfer is compared field by field with the oldest
// pending prediction. Both sides stall in random bursts, and the leash length
// is changed between phases while the block is idle.
`timescale 1ns / 1ps

module tb_force_impulse_and_stretch_stats_top;

    import fias_pkg::*;

    localparam int          FRAC        = 16;
    localparam int          SETTLE      = 150;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam logic [31:0] LEASH_RESET = 32'd98304;

    typedef struct packed {
        logic [31:0] ts;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [31:0] reach;
    } t_sample;

    typedef struct packed {
        logic        base_only;
        logic [31:0] count;
        logic [62:0] impulse;
        logic [31:0] mean;
        logic [31:0] variance;
        logic [31:0] peak;
    } t_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_timestamp = '0;
    logic [31:0] i_force_x = '0;
    logic [31:0] i_force_y = '0;
    logic [31:0] i_force_z = '0;
    logic [31:0] i_distance = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_baseline_only;
    logic [31:0] o_sample_count;
    logic [62:0] o_total_impulse;
    logic [31:0] o_mean_stretch;
    logic [31:0] o_stretch_variance;
    logic [31:0] o_max_stretch;

    force_impulse_and_stretch_stats_top #(.FRAC_BITS(FRAC)) dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [31:0]       leash;
    logic              seeded;
    logic [31:0]       prev_ts;
    longint unsigned   prev_mag;
    longint unsigned   n_samples;
    longint unsigned   impulse_acc;
    longint unsigned   mean_acc;
    longint unsigned   m2_acc;
    longint unsigned   peak_acc;

    t_stats  pending_stats[$];
    int      n_errors = 0;
    int      cycles = 0;
    bit      quiet = 0;
    int      send_gap_left = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_comp(logic [31:0] v);
        return v[31] ? longint'(-v) & 64'hFFFF_FFFF : longint'(v);
    endfunction

    function automatic t_stats snapshot(logic base_only);
        t_stats s;
        longint unsigned var_q;
        var_q = 0;
        if (n_samples >= 2) begin
            var_q = m2_acc / (n_samples - 1);
            if (var_q > 64'hFFFF_FFFF) var_q = 64'hFFFF_FFFF;
        end
        s.base_only = base_only;
        s.count     = n_samples[31:0];
        s.impulse   = impulse_acc[62:0];
        s.mean      = mean_acc[31:0];
        s.variance  = var_q[31:0];
        s.peak      = peak_acc[31:0];
        return s;
    endfunction

    function automatic t_stats predict_stats(t_sample smp);
        longint unsigned ax, ay, az, mag, dt, tsum, area, stretch, ad, ad2, prod;
        longint          delta, stp;
        ax  = abs_comp(smp.fx);
        ay  = abs_comp(smp.fy);
        az  = abs_comp(smp.fz);
        mag = floor_sqrt(ax * ax + ay * ay + az * az);
        if (!seeded) begin
            seeded   = 1;
            prev_ts  = smp.ts;
            prev_mag = mag;
            return snapshot(1'b1);
        end
        if (n_samples < 64'hFFFF_FFFF) n_samples++;
        dt   = {32'd0, smp.ts - prev_ts};
        tsum = prev_mag + mag;
        area = dt * (tsum >> 1);
        if (area > MAX63) area = MAX63;
        if (tsum[0]) begin
            area += dt >> 1;
            if (area > MAX63) area = MAX63;
        end
        impulse_acc = (impulse_acc > MAX63 - area) ? MAX63 : impulse_acc + area;

        stretch  = (smp.reach > leash) ? longint'(smp.reach - leash) : 0;
        delta    = longint'(stretch) - longint'(mean_acc);
        stp      = delta / longint'(n_samples);
        mean_acc = longint'(longint'(mean_acc) + stp) & 64'hFFFF_FFFF;
        ad       = (delta < 0) ? longint'(-delta) : longint'(delta);
        ad2      = (stretch >= mean_acc) ? stretch - mean_acc : mean_acc - stretch;
        prod     = (ad * ad2) >> FRAC;
        m2_acc   = (m2_acc > ~64'd0 - prod) ? ~64'd0 : m2_acc + prod;
        if (stretch > peak_acc) peak_acc = stretch;
        prev_ts  = smp.ts;
        prev_mag = mag;
        return snapshot(1'b0);
    endfunction

    // one sample transfer; valid stays high into the next call unless a gap is taken
    task automatic send_sample(t_sample smp);
        if (!quiet && send_gap_left == 0 && $urandom_range(0, 5) == 0)
            send_gap_left = $urandom_range(1, 13);
        if (send_gap_left > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (send_gap_left - 1) @(negedge i_clk);
            send_gap_left = 0;
        end
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_timestamp = smp.ts;
        i_force_x   = smp.fx;
        i_force_y   = smp.fy;
        i_force_z   = smp.fz;
        i_distance  = smp.reach;
        do @(posedge i_clk); while (!o_ready);
        pending_stats.push_back(predict_stats(smp));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_stats.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_leash(logic [31:0] len);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = len;
        leash      = len;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [31:0] rand_force();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        endcase
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        s.ts = (($urandom_range(0, 19) == 0) ? $urandom() : prev_ts + $urandom_range(0, 4000));
        s.fx = rand_force();
        s.fy = rand_force();
        s.fz = rand_force();
        case ($urandom_range(0, 5))
            0:       s.reach = $urandom();
            1:       s.reach = leash - 32'($urandom_range(0, 32'h0004_0000));
            default: s.reach = leash + 32'($urandom_range(0, 32'h0008_0000));
        endcase
        return s;
    endfunction

    task automatic test_baseline();
        send_sample('{ts: 32'd1000, fx: 32'h0001_0000, fy: 32'h0, fz: 32'h0,
                      reach: 32'h0002_0000});
        send_sample('{ts: 32'd1010, fx: 32'h0, fy: 32'h0003_0000, fz: 32'h0004_0000,
                      reach: 32'h0001_0000});
        send_sample('{ts: 32'd1015, fx: 32'hFFFF_0000, fy: 32'h0, fz: 32'h0,
                      reach: 32'h0003_8000});
    endtask

    task automatic test_extremes();
        // most negative components, then time going backward
        send_sample('{ts: 32'd2000, fx: 32'h8000_0000, fy: 32'h8000_0000, fz: 32'h8000_0000,
                      reach: 32'hFFFF_FFFF});
        send_sample('{ts: 32'd5, fx: 32'h7FFF_FFFF, fy: 32'h7FFF_FFFF, fz: 32'h7FFF_FFFF,
                      reach: 32'h0});
        send_sample('{ts: 32'hFFFF_FFFF, fx: 32'h8000_0000, fy: 32'h7FFF_FFFF, fz: 32'h1,
                      reach: 32'h8000_0000});
        send_sample('{ts: 32'h0, fx: 32'h0, fy: 32'h0, fz: 32'h0, reach: 32'hAAAA_5555});
        send_sample('{ts: 32'h0, fx: 32'h5555_AAAA, fy: 32'hAAAA_5555, fz: 32'hFFFF_FFFF,
                      reach: 32'h5555_AAAA});
    endtask

    task automatic test_leash_settings();
        logic [31:0] lens [4];
        lens = '{32'h0, 32'hFFFF_FFFF, LEASH_RESET, 32'h0010_0000};
        foreach (lens[k]) begin
            set_leash(lens[k]);
            send_sample('{ts: prev_ts + 7, fx: 32'h0002_0000, fy: 32'h0, fz: 32'h0,
                          reach: lens[k] + 32'h0000_8000});
            send_sample('{ts: prev_ts + 3, fx: 32'h0, fy: 32'h0, fz: 32'h0, reach: lens[k]});
            send_sample('{ts: prev_ts + 1, fx: 32'h0, fy: 32'h0, fz: 32'hFFFE_0000,
                          reach: 32'hFFFF_FFFF});
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 850; k++) begin
            if (k % 200 == 199 && k < 780) set_leash($urandom_range(0, 32'h0008_0000));
            if (k == 100) drain(); // hold off until the block has caught up
            if (k == 780) quiet = 1;
            send_sample(rand_sample());
        end
    endtask

    // result side stalls in bursts
    int ready_hold = 0;
    always @(negedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 12);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_stats.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                t_stats e;
                e = pending_stats.pop_front();
                if (o_baseline_only !== e.base_only) begin
                    $error("baseline_only exp %0d got %0d", e.base_only, o_baseline_only);
                    n_errors++;
                end
                if (o_sample_count !== e.count) begin
                    $error("sample_count exp %0d got %0d", e.count, o_sample_count);
                    n_errors++;
                end
                if (o_total_impulse !== e.impulse) begin
                    $error("total_impulse exp %0h got %0h", e.impulse, o_total_impulse);
                    n_errors++;
                end
                if (o_mean_stretch !== e.mean) begin
                    $error("mean_stretch exp %0h got %0h", e.mean, o_mean_stretch);
                    n_errors++;
                end
                if (o_stretch_variance !== e.variance) begin
                    $error("stretch_variance exp %0h got %0h", e.variance, o_stretch_variance);
                    n_errors++;
                end
                if (o_max_stretch !== e.peak) begin
                    $error("max_stretch exp %0h got %0h", e.peak, o_max_stretch);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_force_impulse_and_stretch_stats_top: done, errors");
            $finish;
        end
    end

    initial begin
        leash       = LEASH_RESET;
        seeded      = 0;
        prev_ts     = '0;
        prev_mag    = 0;
        n_samples   = 0;
        impulse_acc = 0;
        mean_acc    = 0;
        m2_acc      = 0;
        peak_acc    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_baseline();
        test_extremes();
        test_leash_settings();
        test_random();
        drain();
        if (n_errors == 0)
            $display("tb_force_impulse_and_stretch_stats_top: done, clean");
        else
            $display("tb_force_impulse_and_stretch_stats_top: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/fias_pkg.sv
src/fias_mul.sv
src/fias_sqrt.sv
src/fias_div.sv
src/force_impulse_and_stretch_stats_top.sv
test/tb_force_impulse_and_stretch_stats_top.sv
